/* design/rfc_pkg.sv */
`default_nettype none

package rfc_pkg;

	// CRC-16 generator, bits enter least significant first
	localparam logic [15:0] CRC_POLY  = 16'h8005;
	// status byte value that means success
	localparam logic [7:0]  STATUS_OK = 8'h00;
	// shortest frame: count, status, two CRC bytes
	localparam logic [7:0]  MIN_FRAME = 8'd4;

	// verdict codes
	localparam logic [1:0] VERDICT_OK      = 2'd0;
	localparam logic [1:0] VERDICT_LENGTH  = 2'd1;
	localparam logic [1:0] VERDICT_CRC     = 2'd2;
	localparam logic [1:0] VERDICT_STATUS  = 2'd3;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       first_of_frame;
	} in_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [7:0]  status_byte;
		logic [15:0] computed_crc;
	} out_t;

	// one byte into the CRC, unrolled over its eight bits
	function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] crc;
		logic        top;
		crc = crc_in;
		for (int i = 0; i < 8; i++) begin
			top = crc[15];
			crc = {crc[14:0], 1'b0};
			if (b[i] != top) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

/* design/rfc_frame_state.sv */
`default_nettype none

module rfc_frame_state (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire rfc_pkg::in_t item,
	input  wire logic [7:0]   expected_count,
	output logic              result_valid,
	output rfc_pkg::out_t     result
);

	logic        active_q;
	logic [7:0]  pos_q;
	logic [15:0] crc_q;
	logic        len_ok_q;
	logic [7:0]  status_q;
	logic        crc_low_ok_q;

	logic [7:0]  len_eff;
	logic [7:0]  len_m2;
	logic        active_eff;
	logic [7:0]  p;
	logic [15:0] crc_cur;
	logic        len_ok_cur;
	logic [7:0]  status_cur;
	logic        crc_low_cur;
	logic        len_ok_new;
	logic [7:0]  status_new;
	logic [15:0] crc_new;
	logic        crc_low_new;
	logic        is_last;
	logic        crc_ok;
	logic [1:0]  verdict;

	// short length settings act as the minimum frame
	assign len_eff = (expected_count < rfc_pkg::MIN_FRAME) ? rfc_pkg::MIN_FRAME
		: expected_count;
	assign len_m2  = len_eff - 8'd2;

	// a frame start mark drops whatever frame was open
	assign active_eff  = item.first_of_frame | active_q;
	assign p           = item.first_of_frame ? 8'd0 : pos_q;
	assign crc_cur     = item.first_of_frame ? 16'd0 : crc_q;
	assign len_ok_cur  = item.first_of_frame ? 1'b0 : len_ok_q;
	assign status_cur  = item.first_of_frame ? 8'd0 : status_q;
	assign crc_low_cur = item.first_of_frame ? 1'b0 : crc_low_ok_q;

	// per-position field capture
	assign len_ok_new = (p == 8'd0) ? (item.rx_byte == len_eff) : len_ok_cur;
	assign status_new = (p == 8'd1) ? item.rx_byte : status_cur;

	// CRC body, low CRC byte, then the closing byte
	always_comb begin
		crc_new     = crc_cur;
		crc_low_new = crc_low_cur;
		is_last     = 1'b0;
		if (p < len_m2) begin
			crc_new = rfc_pkg::crc_add_byte(crc_cur, item.rx_byte);
		end else if (p == len_m2) begin
			crc_low_new = (item.rx_byte == crc_cur[7:0]);
		end else begin
			is_last = 1'b1;
		end
	end

	assign crc_ok = crc_low_cur & (item.rx_byte == crc_cur[15:8]);

	// verdict priority: length, CRC, then status (checked for minimum-length frames only)
	always_comb begin
		priority if (!len_ok_new) begin
			verdict = rfc_pkg::VERDICT_LENGTH;
		end else if (!crc_ok) begin
			verdict = rfc_pkg::VERDICT_CRC;
		end else if ((len_eff == rfc_pkg::MIN_FRAME) &&
			(status_new != rfc_pkg::STATUS_OK)) begin
			verdict = rfc_pkg::VERDICT_STATUS;
		end else begin
			verdict = rfc_pkg::VERDICT_OK;
		end
	end

	assign result_valid        = active_eff & is_last;
	assign result.verdict      = verdict;
	assign result.status_byte  = status_new;
	assign result.computed_crc = crc_cur;

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			pos_q        <= 8'd0;
			crc_q        <= 16'd0;
			len_ok_q     <= 1'b0;
			status_q     <= 8'd0;
			crc_low_ok_q <= 1'b0;
		end else if (step && active_eff) begin
			crc_q        <= crc_new;
			len_ok_q     <= len_ok_new;
			status_q     <= status_new;
			crc_low_ok_q <= crc_low_new;
			if (is_last) begin
				active_q <= 1'b0;
				pos_q    <= 8'd0;
			end else begin
				active_q <= 1'b1;
				pos_q    <= p + 8'd1;
			end
		end
	end

	// closed frame always parks at position zero
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (pos_q == 8'd0))
		else $error("position nonzero with no frame open");

	// a verdict closes the frame
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result_valid) |=> !active_q)
		else $error("frame still open after verdict");

endmodule

`default_nettype wire

/* design/response_frame_checker.sv */
// A verdict reaches the output from the frame's last byte through the input
// register, then the result register.
// Throughput: one byte per cycle when not stalled; the CRC update is XOR logic.
// While a verdict waits on a stalled output, one more byte is taken into the
// input register and then the input stalls.
// Reset: control state and frame state clear, no frame open; expected_count is 4.
`default_nettype none

module response_frame_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire rfc_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output rfc_pkg::out_t      out_data,
	input  wire logic          cfg_wr_en,
	input  wire logic [7:0]    cfg_wr_data
);

	logic          valid_s1;
	rfc_pkg::in_t  data_s1;
	logic          out_valid_q;
	rfc_pkg::out_t out_data_q;
	logic [7:0]    expected_count_q;

	logic          adv;
	logic          in_xfer;
	logic          res_valid;
	rfc_pkg::out_t res;

	// the staged byte moves on whenever the result slot is free or draining
	assign adv      = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign in_xfer  = in_valid & ~in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_count_q <= rfc_pkg::MIN_FRAME;
		end else if (cfg_wr_en) begin
			expected_count_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1 <= in_data;
		end
	end

	rfc_frame_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv),
		.item           (data_s1),
		.expected_count (expected_count_q),
		.result_valid   (res_valid),
		.result         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// stall toward the source only with a byte staged
	a_stall_staged: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	// a new verdict only comes from a staged byte that moved on
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv))
		else $error("verdict without a processed byte");

endmodule

`default_nettype wire
